// ===== src/two_pulse_channel_sound_generator_macros.svh =====
// assertion helpers for the pulse channel sound block
`ifndef TWO_PULSE_CHANNEL_SOUND_GENERATOR_MACROS_SVH
`define TWO_PULSE_CHANNEL_SOUND_GENERATOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define TPC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tpcsg: implication failed");
// next-cycle implication
`define TPC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tpcsg: next-cycle implication failed");
`else
`define TPC_ASSERT_NOW(label, pre, post)
`define TPC_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== src/tpcsg_pkg.sv =====
package tpcsg_pkg;

    localparam int CH_COUNT = 2;

    localparam logic [11:0] INTERVAL_RESET = 12'd3728;
    localparam logic [10:0] PERIOD_MIN     = 11'd8;

    // input kind carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // register map
    localparam logic [15:0] ADDR_CH0_CTRL   = 16'h4000;
    localparam logic [15:0] ADDR_CH0_PER_LO = 16'h4002;
    localparam logic [15:0] ADDR_CH0_PER_HI = 16'h4003;
    localparam logic [15:0] ADDR_CH1_CTRL   = 16'h4004;
    localparam logic [15:0] ADDR_CH1_PER_LO = 16'h4006;
    localparam logic [15:0] ADDR_CH1_PER_HI = 16'h4007;
    localparam logic [15:0] ADDR_STATUS     = 16'h4015;

    typedef struct packed {
        logic [1:0]  duty;
        logic        loop_en;
        logic        const_vol;
        logic [3:0]  volume;
        logic [10:0] period;
        logic [10:0] countdown;
        logic [2:0]  step;
        logic [3:0]  decay;
        logic        enable;
    } chan_t;

    localparam chan_t CHAN_RESET = '{
        duty: 2'd0, loop_en: 1'b0, const_vol: 1'b0, volume: 4'd0,
        period: 11'd0, countdown: 11'd0, step: 3'd0, decay: 4'd0,
        enable: 1'b1
    };

    typedef struct packed {
        logic [14:0] mixed_sample;
        logic [4:0]  level_sum;
        logic [3:0]  level_second;
        logic [3:0]  level_first;
    } result_t;

    // duty waveforms, bit n is step n
    localparam logic [7:0] DUTY_PATTERN [4] = '{
        8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
    };

    // mixer curve, Q0.15, indexed by level sum
    localparam logic [14:0] MIX_TABLE [31] = '{
        15'd0,     15'd824,   15'd1647,  15'd2468,  15'd3288,  15'd4106,
        15'd4923,  15'd5739,  15'd6554,  15'd7367,  15'd8179,  15'd8990,
        15'd9799,  15'd10607, 15'd11414, 15'd12219, 15'd13023, 15'd13826,
        15'd14627, 15'd15427, 15'd16226, 15'd17024, 15'd17820, 15'd18615,
        15'd19409, 15'd20201, 15'd20992, 15'd21782, 15'd22571, 15'd23358,
        15'd24144
    };

    function automatic logic [3:0] chan_level(input chan_t ch);
        logic [7:0] pattern;
        logic [3:0] vol;
        pattern = DUTY_PATTERN[ch.duty];
        vol     = ch.const_vol ? ch.volume : ch.decay;
        if (!ch.enable || (ch.period < PERIOD_MIN) || !pattern[ch.step])
        begin
            return 4'd0;
        end
        return vol;
    endfunction

endpackage

// ===== src/two_pulse_channel_sound_generator.sv =====
// pipeline: an accepted input transaction updates the channel state and sets pend; the
// result register then loads from that state once the result stage is empty or draining
// throughput: one transaction per cycle while the sink accepts results; the channel state
// updates at acceptance and one result stage holds the mixed sample while the sink stalls
// reset: rst_n asynchronous active low; channels enabled, other channel and control state
// zero, envelope interval 3728 ticks; the result payload register is not reset
module two_pulse_channel_sound_generator (
    input  logic        clk,
    input  logic        rst_n,
    // envelope interval register
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address [15:0], write_data [23:16]
    input  logic        s_tuser,   // opcode: 0 register write, 1 tick
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // level_first [3:0], level_second [7:4],
                                   // level_sum [12:8], mixed_sample [27:13]
);

`include "two_pulse_channel_sound_generator_macros.svh"

    tpcsg_pkg::chan_t   chan_reg [tpcsg_pkg::CH_COUNT];
    tpcsg_pkg::chan_t   chan_next [tpcsg_pkg::CH_COUNT];
    logic [11:0]        frame_reg, frame_next;
    logic [11:0]        interval_reg;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    tpcsg_pkg::result_t out_reg;
    tpcsg_pkg::result_t result;

    logic        accept;
    logic        out_load;
    logic        is_tick;
    logic        env_clk;
    logic [11:0] frame_inc;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;

    assign wr_addr = s_tdata[15:0];
    assign wr_data = s_tdata[23:16];
    assign is_tick = (s_tuser == tpcsg_pkg::OP_TICK);

    // handshake: pend marks that the channel state holds an item not yet
    // moved into the result stage
    assign out_load = pend_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    // frame divider for the envelope clock
    assign frame_inc = frame_reg + 12'd1;
    assign env_clk   = (frame_inc >= interval_reg);

    always_comb
    begin
        frame_next = frame_reg;
        for (int c = 0; c < tpcsg_pkg::CH_COUNT; c++)
        begin
            chan_next[c] = chan_reg[c];
        end
        if (accept && is_tick)
        begin
            frame_next = env_clk ? 12'd0 : frame_inc;
            for (int c = 0; c < tpcsg_pkg::CH_COUNT; c++)
            begin
                // timer reload advances the sequencer
                if (chan_reg[c].countdown == 11'd0)
                begin
                    chan_next[c].countdown = chan_reg[c].period;
                    chan_next[c].step      = chan_reg[c].step + 3'd1;
                end
                else
                begin
                    chan_next[c].countdown = chan_reg[c].countdown - 11'd1;
                end
                // envelope decay, or reload when looping at zero
                if (env_clk && !chan_reg[c].const_vol)
                begin
                    if (chan_reg[c].decay != 4'd0)
                    begin
                        chan_next[c].decay = chan_reg[c].decay - 4'd1;
                    end
                    else if (chan_reg[c].loop_en)
                    begin
                        chan_next[c].decay = chan_reg[c].volume;
                    end
                end
            end
        end
        else if (accept)
        begin
            case (wr_addr)
                tpcsg_pkg::ADDR_CH0_CTRL:
                begin
                    chan_next[0].duty      = wr_data[7:6];
                    chan_next[0].loop_en   = wr_data[5];
                    chan_next[0].const_vol = wr_data[4];
                    chan_next[0].volume    = wr_data[3:0];
                end
                tpcsg_pkg::ADDR_CH0_PER_LO:
                begin
                    chan_next[0].period[7:0] = wr_data;
                end
                tpcsg_pkg::ADDR_CH0_PER_HI:
                begin
                    chan_next[0].period[10:8] = wr_data[2:0];
                    chan_next[0].step         = 3'd0;
                    chan_next[0].decay        = chan_reg[0].volume;
                end
                tpcsg_pkg::ADDR_CH1_CTRL:
                begin
                    chan_next[1].duty      = wr_data[7:6];
                    chan_next[1].loop_en   = wr_data[5];
                    chan_next[1].const_vol = wr_data[4];
                    chan_next[1].volume    = wr_data[3:0];
                end
                tpcsg_pkg::ADDR_CH1_PER_LO:
                begin
                    chan_next[1].period[7:0] = wr_data;
                end
                tpcsg_pkg::ADDR_CH1_PER_HI:
                begin
                    chan_next[1].period[10:8] = wr_data[2:0];
                    chan_next[1].step         = 3'd0;
                    chan_next[1].decay        = chan_reg[1].volume;
                end
                tpcsg_pkg::ADDR_STATUS:
                begin
                    chan_next[0].enable = wr_data[0];
                    chan_next[1].enable = wr_data[1];
                end
                default:
                begin
                    // unmapped address, state untouched
                end
            endcase
        end
    end

    // result from the state as it stands after the pending item
    always_comb
    begin
        result.level_first  = tpcsg_pkg::chan_level(chan_reg[0]);
        result.level_second = tpcsg_pkg::chan_level(chan_reg[1]);
        result.level_sum    = {1'b0, result.level_first} + {1'b0, result.level_second};
        result.mixed_sample = tpcsg_pkg::MIX_TABLE[result.level_sum];
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (out_load)
        begin
            pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < tpcsg_pkg::CH_COUNT; c++)
            begin
                chan_reg[c] <= tpcsg_pkg::CHAN_RESET;
            end
            frame_reg     <= 12'd0;
            interval_reg  <= tpcsg_pkg::INTERVAL_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < tpcsg_pkg::CH_COUNT; c++)
            begin
                chan_reg[c] <= chan_next[c];
            end
            frame_reg     <= frame_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

    // pending state is never dropped while the result stage is blocked
    `TPC_ASSERT_NEXT(a_pend_held, pend_reg && !out_load, pend_reg)
    // input stalls only when both the state and the result stage are occupied
    `TPC_ASSERT_NOW(a_ready_stall, !s_tready, pend_reg && out_valid_reg && !m_tready)
    // delivered sum always matches the two channel levels
    `TPC_ASSERT_NOW(a_sum_consistent, out_valid_reg,
        out_reg.level_sum == ({1'b0, out_reg.level_first} + {1'b0, out_reg.level_second}))
    // an envelope clock restarts the frame count
    `TPC_ASSERT_NEXT(a_frame_restart, accept && is_tick && env_clk, frame_reg == 12'd0)

endmodule
